@@ hdl/hypersphere_step_to_cartesian_macros.svh @@
// Assertion macros for the hypersphere step converter.
// Used by the top level; expects signals named clk and rst in scope.
`ifndef HYPERSPHERE_STEP_TO_CARTESIAN_MACROS_SVH
`define HYPERSPHERE_STEP_TO_CARTESIAN_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define HSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsc: next-cycle check failed");

`endif

@@ hdl/hsc_pkg.sv @@
// Package for the hypersphere step converter: sequencer states and CORDIC constants.
// No dependencies; used by hypersphere_step_to_cartesian.
package hsc_pkg;

  // Number of CORDIC rotations and the width of their counter.
  localparam int unsigned CORDIC_ITERS = 24;
  localparam int unsigned ITER_W = 5;

  // CORDIC gain compensation, Q1.30.
  localparam logic signed [31:0] CORDIC_GAIN = 32'sh26DD3B6A;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_MAP,
    ST_MUL_C,
    ST_RND_C,
    ST_MUL_S,
    ST_RND_S
  } state_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

@@ hdl/hypersphere_step_to_cartesian.sv @@
// Converts walk steps from n-dimensional spherical form to Cartesian coordinates.
// Radius item: accepted in ST_IDLE, no result. Angle item: CORDIC rotations, a quadrant
// map, then multiply and round twice on one shared multiplier; the first coordinate
// is registered from ST_RND_C (the final sine coordinate from ST_RND_S), and the next
// item is taken back in ST_IDLE, later while a result waits on out_stall.
// Reset (rst, synchronous, active high): dims returns to 3, a new step expects a radius.
module hypersphere_step_to_cartesian #(
  parameter int unsigned MAX_DIMS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port for dims.
  input  logic               dims_we,
  input  logic [3:0]         dims_data,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [31:0]        sample,
  // Output channel.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] coordinate,
  output logic [2:0]         axis,
  output logic               last_of_step
);

  localparam logic [3:0] MaxDimsW = 4'(MAX_DIMS);
  localparam logic [hsc_pkg::ITER_W-1:0] LastIter = hsc_pkg::ITER_W'(hsc_pkg::CORDIC_ITERS - 1);
  localparam logic signed [64:0] RoundBias = 65'sd536870912;
  localparam logic signed [64:0] SMax = 65'sd2147483647;
  localparam logic signed [64:0] SMin = -65'sd2147483648;
  localparam logic signed [64:0] UMax = 65'sd4294967295;

  hsc_pkg::state_t state, state_next;

  logic [3:0]                  dims;
  logic [3:0]                  position;
  logic [31:0]                 running_product;
  logic [hsc_pkg::ITER_W-1:0]  iter;
  logic signed [31:0]          x, y, z;
  logic [1:0]                  quad;
  logic                        final_q;
  logic [2:0]                  axis_q;
  logic [2:0]                  last_axis_q;
  logic signed [31:0]          cos_q, sin_q;
  logic signed [64:0]          prod;

  logic [3:0]         dims_eff;
  logic               final_angle;
  logic [31:0]        phase;
  logic               in_accept;
  logic               slot_free;
  logic               load_out_c;
  logic               load_out_s;
  logic               load_rp;
  logic signed [31:0] mul_b;
  logic signed [64:0] rnd_sum;
  logic signed [64:0] shifted;
  logic signed [31:0] sat_s;
  logic [31:0]        sat_u;
  logic signed [31:0] dx, dy;
  logic [31:0]        atan_val;

  // Effective dimension count and the angle phase of the incoming item.
  always_comb begin
    if (dims < 4'd2) begin
      dims_eff = 4'd2;
    end else if (dims > MaxDimsW) begin
      dims_eff = MaxDimsW;
    end else begin
      dims_eff = dims;
    end
    final_angle = (position >= (dims_eff - 4'd1));
    phase = final_angle ? sample : {1'b0, sample[31:1]};
  end

  assign in_accept = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      hsc_pkg::ST_IDLE: begin
        if (in_accept && (position != 4'd0)) begin
          state_next = hsc_pkg::ST_ROTATE;
        end
      end
      hsc_pkg::ST_ROTATE: begin
        if (iter == LastIter) begin
          state_next = hsc_pkg::ST_MAP;
        end
      end
      hsc_pkg::ST_MAP:   state_next = hsc_pkg::ST_MUL_C;
      hsc_pkg::ST_MUL_C: state_next = hsc_pkg::ST_RND_C;
      hsc_pkg::ST_RND_C: begin
        if (slot_free) begin
          state_next = hsc_pkg::ST_MUL_S;
        end
      end
      hsc_pkg::ST_MUL_S: state_next = hsc_pkg::ST_RND_S;
      hsc_pkg::ST_RND_S: begin
        if (!final_q || slot_free) begin
          state_next = hsc_pkg::ST_IDLE;
        end
      end
      default: state_next = hsc_pkg::ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_stall   = 1'b1;
    load_out_c = 1'b0;
    load_out_s = 1'b0;
    load_rp    = 1'b0;
    case (state)
      hsc_pkg::ST_IDLE:  in_stall = 1'b0;
      hsc_pkg::ST_RND_C: load_out_c = slot_free;
      hsc_pkg::ST_RND_S: begin
        load_out_s = final_q && slot_free;
        load_rp    = !final_q;
      end
      default: in_stall = 1'b1;
    endcase
  end

  // Shared multiplier operand and the rounding and saturation of its product.
  always_comb begin
    mul_b   = (state == hsc_pkg::ST_MUL_S) ? sin_q : cos_q;
    rnd_sum = prod + RoundBias;
    shifted = rnd_sum >>> 30;
    if (shifted > SMax) begin
      sat_s = 32'sh7FFFFFFF;
    end else if (shifted < SMin) begin
      sat_s = 32'sh80000000;
    end else begin
      sat_s = shifted[31:0];
    end
    if (shifted < 65'sd0) begin
      sat_u = 32'h0;
    end else if (shifted > UMax) begin
      sat_u = 32'hFFFFFFFF;
    end else begin
      sat_u = shifted[31:0];
    end
  end

  // One CORDIC rotation: floor shifts and the arctangent of this step.
  always_comb begin
    dx       = y >>> iter;
    dy       = x >>> iter;
    atan_val = hsc_pkg::atan_turn(iter);
  end

  // Sequencer state and the configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hsc_pkg::ST_IDLE;
      dims  <= 4'd3;
    end else begin
      state <= state_next;
      if (dims_we) begin
        dims <= dims_data;
      end
    end
  end

  // Step position and running product of radius and sines.
  always_ff @(posedge clk) begin
    if (rst) begin
      position        <= 4'd0;
      running_product <= 32'h0;
    end else if (in_accept && (position == 4'd0)) begin
      position        <= 4'd1;
      running_product <= sample;
    end else if (load_rp) begin
      position        <= position + 4'd1;
      running_product <= sat_u;
    end else if (load_out_s) begin
      position        <= 4'd0;
    end
  end

  // CORDIC datapath, quadrant map and the shared multiplier.
  always_ff @(posedge clk) begin
    if (in_accept && (position != 4'd0)) begin
      x           <= hsc_pkg::CORDIC_GAIN;
      y           <= 32'sd0;
      z           <= signed'({2'b00, phase[29:0]});
      quad        <= phase[31:30];
      final_q     <= final_angle;
      axis_q      <= 3'(position - 4'd1);
      last_axis_q <= 3'(dims_eff - 4'd1);
      iter        <= '0;
    end else if (state == hsc_pkg::ST_ROTATE) begin
      if (!z[31]) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - signed'(atan_val);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + signed'(atan_val);
      end
      iter <= iter + 1'b1;
    end
    if (state == hsc_pkg::ST_MAP) begin
      case (quad)
        2'd0: begin
          cos_q <= x;
          sin_q <= y;
        end
        2'd1: begin
          cos_q <= -y;
          sin_q <= x;
        end
        2'd2: begin
          cos_q <= -x;
          sin_q <= -y;
        end
        default: begin
          cos_q <= y;
          sin_q <= -x;
        end
      endcase
    end
    if ((state == hsc_pkg::ST_MUL_C) || (state == hsc_pkg::ST_MUL_S)) begin
      prod <= signed'({1'b0, running_product}) * mul_b;
    end
  end

  // Output register: holds one result until the transaction completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out_c || load_out_s) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out_c) begin
      coordinate   <= sat_s;
      axis         <= axis_q;
      last_of_step <= 1'b0;
    end else if (load_out_s) begin
      coordinate   <= sat_s;
      axis         <= last_axis_q;
      last_of_step <= 1'b1;
    end
  end

`include "hypersphere_step_to_cartesian_macros.svh"

  // An accepted angle starts the rotation loop.
  `HSC_ASSERT_NEXT(a_angle_starts, in_accept && (position != 4'd0), state == hsc_pkg::ST_ROTATE)
  // The rotation loop ends after its last iteration.
  `HSC_ASSERT_NEXT(a_rotate_ends, (state == hsc_pkg::ST_ROTATE) && (iter == LastIter), state == hsc_pkg::ST_MAP)
  // The step position never passes the largest dimension count.
  `HSC_ASSERT_NOW(a_position_range, 1'b1, position < MaxDimsW)
  // A result is only loaded when the output register can take it.
  `HSC_ASSERT_NOW(a_load_free, load_out_c || load_out_s, slot_free)

endmodule
